[design/stq_pkg.sv]
// Shared types and constants for the sorted timer event queue.
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 64;
	localparam int TPS_W       = 32;
	localparam int DELAY_W     = 32;
	localparam int TAG_W       = 8;
	localparam int PENDING_W   = 5;

	localparam logic [TPS_W-1:0] TPS_RESET = 32'd62500000;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_FULL       = 2'd1,
		STATUS_NOT_INSERT = 2'd2
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

[design/stq_cell.sv]
// One slot of the sorted timer chain: holds one entry and shifts with its neighbors.
module stq_cell (
	input  logic              clk,
	input  stq_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  logic              prev_keep,
	input  stq_pkg::entry_t   prev_entry,
	input  stq_pkg::entry_t   next_entry,
	output stq_pkg::entry_t   entry,
	output logic              keep
);
	import stq_pkg::*;

	entry_t entry_q;

	// An occupied slot at or before the new expiry stays; because the chain is sorted
	// these slots form a prefix, and the first slot after it takes the new entry.
	assign keep  = occupied && (entry_q.expiry <= ctl.new_entry.expiry);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (!keep) begin
				entry_q <= prev_keep ? ctl.new_entry : prev_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

[design/sorted_timer_event_queue.sv]
// Top level of the sorted timer event queue: control, expiry arithmetic and the cell chain.
//
//  channel   direction  signals                       payload
//  s_*       in         s_tvalid s_tready s_tdata     tdata: delay_seconds, tag
//                       s_tuser                       tuser: func
//  m_*       out        m_tvalid m_tready m_tdata     tdata: fired_tag, pending
//                       m_tuser                       tuser: fired, insert_status
//  cfg_*     in         cfg_we cfg_wdata              ticks_per_second
//
// For a tick, the counter increment, the head compare and the pop all happen at the edge
// that accepts it. An insert runs through accept, 32x32 multiply, 64-bit expiry add,
// then the compare-and-shift across the cells, which waits for a free output register.
// Reset clears the counter and the fill count and loads ticks_per_second with 62500000.
// A finished result sits in the output register; the next item is taken only once that
// register is free or being read in the same cycle.
module sorted_timer_event_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] delay_seconds, [39:32] tag
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] fired_tag, [12:8] pending, [15:13] zero
	output logic [2:0]  m_tuser,   // [0] fired, [2:1] insert_status
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import stq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_INS
	} state_t;

	state_t                state_q;
	logic [TPS_W-1:0]      tps_q;
	logic [TIME_W-1:0]     cnt_q;
	logic [CNT_W-1:0]      count_q;
	logic [DELAY_W-1:0]    delay_q;
	logic [TAG_W-1:0]      tag_q;
	logic [TIME_W-1:0]     prod_q;
	logic [TIME_W-1:0]     expiry_q;
	logic                  m_valid_q;
	logic                  fired_q;
	logic [TAG_W-1:0]      fired_tag_q;
	status_t               status_q;

	logic                  out_free;
	logic                  in_xact;
	logic                  tick_go;
	logic [TIME_W-1:0]     cnt_inc;
	logic                  head_due;
	logic                  is_full;
	logic                  ins_go;
	cell_ctl_t             ctl;
	entry_t                cells [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] keeps;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_xact  = s_tvalid && s_tready;
	assign tick_go  = in_xact && (s_tuser == FUNC_TICK);
	assign cnt_inc  = cnt_q + TIME_W'(1);
	assign head_due = (count_q != '0) && (cells[0].expiry <= cnt_inc);
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign ins_go   = (state_q == ST_INS) && out_free && !is_full;

	assign ctl.insert           = ins_go;
	assign ctl.pop              = tick_go && head_due;
	assign ctl.new_entry.expiry = expiry_q;
	assign ctl.new_entry.tag    = tag_q;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			stq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occupied   (CNT_W'(gi) < count_q),
				.prev_keep  ((gi == 0) ? 1'b1 : keeps[(gi == 0) ? 0 : gi - 1]),
				.prev_entry (cells[(gi == 0) ? 0 : gi - 1]),
				.next_entry (cells[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
				.entry      (cells[gi]),
				.keep       (keeps[gi])
			);
		end
	endgenerate

	// Item payload and the expiry arithmetic carry no reset.
	always_ff @(posedge clk) begin
		if (in_xact) begin
			delay_q <= s_tdata[DELAY_W-1:0];
			tag_q   <= s_tdata[DELAY_W +: TAG_W];
		end
		if (state_q == ST_MUL) begin
			prod_q <= TIME_W'(delay_q) * TIME_W'(tps_q);
		end
		if (state_q == ST_ADD) begin
			expiry_q <= cnt_q + prod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tps_q       <= TPS_RESET;
			cnt_q       <= '0;
			count_q     <= '0;
			m_valid_q   <= 1'b0;
			fired_q     <= 1'b0;
			fired_tag_q <= '0;
			status_q    <= STATUS_NOT_INSERT;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_wdata;
			end
			if (tick_go || ((state_q == ST_INS) && out_free)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_go) begin
						cnt_q       <= cnt_inc;
						fired_q     <= head_due;
						fired_tag_q <= head_due ? cells[0].tag : '0;
						status_q    <= STATUS_NOT_INSERT;
						if (head_due) begin
							count_q <= count_q - CNT_W'(1);
						end
					end else if (in_xact) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						fired_q     <= 1'b0;
						fired_tag_q <= '0;
						status_q    <= is_full ? STATUS_FULL : STATUS_OK;
						if (!is_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, PENDING_W'(count_q), fired_tag_q};
	assign m_tuser  = {status_q, fired_q};

	// The fill count never passes the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("timer queue fill count beyond depth");

	// A timer only fires on a tick item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && fired_q) |-> (status_q == STATUS_NOT_INSERT))
		else $error("fired flag set on an insert result");

	// An accepted tick produces its result on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == FUNC_TICK)) |=> m_tvalid)
		else $error("tick result missing");

	// The fill count only moves together with a new result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> m_tvalid)
		else $error("fill count changed without a result");

endmodule
